// ===== design/palette_key_team_recolor_macros.svh =====
// Assertion macros for the palette key team recolor block.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef PALETTE_KEY_TEAM_RECOLOR_MACROS_SVH
`define PALETTE_KEY_TEAM_RECOLOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PRK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prk assertion failed");

// Implication with a fixed delay in cycles, checked outside reset
`define PRK_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("prk delayed assertion failed");

`endif

// ===== design/prk_pkg.sv =====
// Shared types, key palette and arithmetic constants for the recolor block.
// No dependencies; used by every module of the block.
package prk_pkg;

    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int KEY_COUNT = 19;
    localparam int IDX_W     = $clog2(KEY_COUNT);
    localparam int REF_INDEX = 14;
    localparam int PROD_W    = 13;

    // x / 5 as (x * 205) >> 10, exact for x below 1024
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;
    localparam int QUOT_IN_W  = 10;
    localparam int DIV5_W     = QUOT_IN_W + 8;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TEAM0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEAM1 = 2'd1;

    localparam logic [RGB_W-1:0] TEAM0_RESET = 24'h2E419B;
    localparam logic [RGB_W-1:0] TEAM1_RESET = 24'hFF0000;

    // Magenta key shades, darkest first; index 14 is the reference shade
    localparam logic [RGB_W-1:0] KEY_TABLE [KEY_COUNT] = '{
        24'h3F0016, 24'h55002A, 24'h690039, 24'h7B0045, 24'h8C0051,
        24'h9E005D, 24'hB10069, 24'hC30074, 24'hD6007F, 24'hEC008C,
        24'hEE3D96, 24'hEF5BA1, 24'hF172AC, 24'hF287B6, 24'hF49AC1,
        24'hF6ADCD, 24'hF8C1D9, 24'hFAD5E5, 24'hFDE9F1
    };

    // Per-channel shading modes
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_DARK  = 2'd1;
    localparam logic [1:0] MODE_REF   = 2'd2;
    localparam logic [1:0] MODE_LIGHT = 2'd3;

    // Stage 1 word handed from the key matcher to the channel shaders
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] ref_rgb;
        logic [RGB_W-1:0] pix_rgb;
    } t_match;

endpackage

// ===== design/palette_key_team_recolor.sv =====
// An accepted start's o_valid strobe passes the r_valid, r_v2 and r_v3 registers.
// Throughput: one pixel word per cycle unless busy; the match, multiply and scale stages
// are registered. busy is high only in reset and the cycle after; no stall from output.
// Reset (synchronous, active low) clears valid bits and loads the default team colors.
// Top level of the palette key team recolor block; uses prk_pkg, prk_match, prk_chan.
`include "palette_key_team_recolor_macros.svh"
module palette_key_team_recolor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [prk_pkg::CHAN_W-1:0]      i_red,
    input  logic [prk_pkg::CHAN_W-1:0]      i_green,
    input  logic [prk_pkg::CHAN_W-1:0]      i_blue,
    input  logic [prk_pkg::CHAN_W-1:0]      i_alpha,
    input  logic                            i_team_select,
    input  logic                            i_cfg_we,
    input  logic [prk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prk_pkg::RGB_W-1:0]       i_cfg_data,
    output logic                            o_valid,
    output logic [prk_pkg::CHAN_W-1:0]      o_red,
    output logic [prk_pkg::CHAN_W-1:0]      o_green,
    output logic [prk_pkg::CHAN_W-1:0]      o_blue,
    output logic [prk_pkg::CHAN_W-1:0]      o_alpha,
    output logic                            o_key_matched
);

    logic                           r_busy;
    logic [prk_pkg::RGB_W-1:0]      r_team0;
    logic [prk_pkg::RGB_W-1:0]      r_team1;
    logic                           accept;
    logic [prk_pkg::RGB_W-1:0]      ref_rgb;

    logic                           s1_valid;
    prk_pkg::t_match                s1_match;

    logic                           r_v2;
    logic                           r_v3;
    logic                           r_hit2;
    logic                           r_hit3;
    logic [prk_pkg::CHAN_W-1:0]     r_a1;
    logic [prk_pkg::CHAN_W-1:0]     r_a2;
    logic [prk_pkg::CHAN_W-1:0]     r_a3;

    assign accept  = start && !busy;
    assign ref_rgb = i_team_select ? r_team1 : r_team0;

    // Busy only around reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // Team color registers; other indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_team0 <= prk_pkg::TEAM0_RESET;
            r_team1 <= prk_pkg::TEAM1_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == prk_pkg::REG_TEAM0) begin
                r_team0 <= i_cfg_data;
            end
            if (i_cfg_idx == prk_pkg::REG_TEAM1) begin
                r_team1 <= i_cfg_data;
            end
        end
    end

    // Stage 1: key match
    prk_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_pix_rgb ({i_red, i_green, i_blue}),
        .i_ref_rgb (ref_rgb),
        .o_valid   (s1_valid),
        .o_match   (s1_match)
    );

    // Stages 2 and 3: one shader per channel
    prk_chan u_chan_r (
        .i_clk  (i_clk),
        .i_hit  (s1_match.hit),
        .i_idx  (s1_match.idx),
        .i_ref  (s1_match.ref_rgb[23:16]),
        .i_pix  (s1_match.pix_rgb[23:16]),
        .o_chan (o_red)
    );

    prk_chan u_chan_g (
        .i_clk  (i_clk),
        .i_hit  (s1_match.hit),
        .i_idx  (s1_match.idx),
        .i_ref  (s1_match.ref_rgb[15:8]),
        .i_pix  (s1_match.pix_rgb[15:8]),
        .o_chan (o_green)
    );

    prk_chan u_chan_b (
        .i_clk  (i_clk),
        .i_hit  (s1_match.hit),
        .i_idx  (s1_match.idx),
        .i_ref  (s1_match.ref_rgb[7:0]),
        .i_pix  (s1_match.pix_rgb[7:0]),
        .o_chan (o_blue)
    );

    // Valid bits alongside the channel stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= s1_valid;
            r_v3 <= r_v2;
        end
    end

    // Alpha and match flag delay line
    always_ff @(posedge i_clk) begin
        r_a1   <= i_alpha;
        r_a2   <= r_a1;
        r_a3   <= r_a2;
        r_hit2 <= s1_match.hit;
        r_hit3 <= r_hit2;
    end

    assign o_valid       = r_v3;
    assign o_alpha       = r_a3;
    assign o_key_matched = r_hit3;

    // Checks
    `PRK_ASSERT_DLY(a_latency, accept, 3, o_valid)
    `PRK_ASSERT_IMP(a_no_spurious, o_valid, $past(accept, 3))
    `PRK_ASSERT_IMP(a_alpha_thru, o_valid, o_alpha == $past(i_alpha, 3))
    `PRK_ASSERT_IMP(a_pass_thru, o_valid && !o_key_matched,
                    o_red == $past(i_red, 3) && o_blue == $past(i_blue, 3))

endmodule

// ===== design/prk_match.sv =====
// Stage 1: compares the pixel RGB against the key palette and registers the team color.
// Depends on prk_pkg.
module prk_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [prk_pkg::RGB_W-1:0]   i_pix_rgb,
    input  logic [prk_pkg::RGB_W-1:0]   i_ref_rgb,
    output logic                        o_valid,
    output prk_pkg::t_match             o_match
);

    logic                    r_valid;
    prk_pkg::t_match         r_match;
    prk_pkg::t_match         n_match;

    // Parallel compare against all keys; entries are distinct
    always_comb begin
        n_match.hit     = 1'b0;
        n_match.idx     = '0;
        n_match.ref_rgb = i_ref_rgb;
        n_match.pix_rgb = i_pix_rgb;
        for (int k = 0; k < prk_pkg::KEY_COUNT; k++) begin
            if (prk_pkg::KEY_TABLE[k] == i_pix_rgb) begin
                n_match.hit = 1'b1;
                n_match.idx = prk_pkg::IDX_W'(k);
            end
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_match <= n_match;
    end

    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

// ===== design/prk_chan.sv =====
// Stages 2 and 3 for one color channel: one multiply, then scale and offset.
// Depends on prk_pkg.
module prk_chan (
    input  logic                        i_clk,
    input  logic                        i_hit,
    input  logic [prk_pkg::IDX_W-1:0]   i_idx,
    input  logic [prk_pkg::CHAN_W-1:0]  i_ref,
    input  logic [prk_pkg::CHAN_W-1:0]  i_pix,
    output logic [prk_pkg::CHAN_W-1:0]  o_chan
);

    localparam logic [prk_pkg::IDX_W-1:0] RefIdx = prk_pkg::IDX_W'(prk_pkg::REF_INDEX);

    logic [1:0]                   n_mode;
    logic [prk_pkg::CHAN_W-1:0]   mul_a;
    logic [prk_pkg::IDX_W-1:0]    mul_b;
    logic [prk_pkg::PROD_W-1:0]   n_prod;

    logic [1:0]                   r_mode;
    logic [prk_pkg::PROD_W-1:0]   r_prod;
    logic [prk_pkg::CHAN_W-1:0]   r_ref;
    logic [prk_pkg::CHAN_W-1:0]   r_pix;

    logic [prk_pkg::DIV5_W-1:0]   div_prod;
    logic [prk_pkg::CHAN_W-1:0]   n_chan;
    logic [prk_pkg::CHAN_W-1:0]   r_chan;

    // Stage 2: mode decode and shared multiplier
    // dark: c * (i + 2); light: (i - 14) * (255 - c)
    always_comb begin
        if (!i_hit) begin
            n_mode = prk_pkg::MODE_PASS;
        end else if (i_idx < RefIdx) begin
            n_mode = prk_pkg::MODE_DARK;
        end else if (i_idx == RefIdx) begin
            n_mode = prk_pkg::MODE_REF;
        end else begin
            n_mode = prk_pkg::MODE_LIGHT;
        end
        if (n_mode == prk_pkg::MODE_DARK) begin
            mul_a = i_ref;
            mul_b = i_idx + prk_pkg::IDX_W'(2);
        end else begin
            mul_a = ~i_ref;
            mul_b = i_idx - RefIdx;
        end
        n_prod = prk_pkg::PROD_W'(mul_a) * prk_pkg::PROD_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_prod <= n_prod;
        r_ref  <= i_ref;
        r_pix  <= i_pix;
    end

    // Stage 3: divide by 16 or by 5, then select
    assign div_prod = prk_pkg::DIV5_W'(r_prod[prk_pkg::QUOT_IN_W-1:0])
                      * prk_pkg::DIV5_W'(prk_pkg::DIV5_MUL);

    always_comb begin
        case (r_mode)
            prk_pkg::MODE_PASS:  n_chan = r_pix;
            prk_pkg::MODE_DARK:  n_chan = r_prod[prk_pkg::CHAN_W+3:4];
            prk_pkg::MODE_REF:   n_chan = r_ref;
            prk_pkg::MODE_LIGHT: n_chan = r_ref
                                 + div_prod[prk_pkg::DIV5_W-1:prk_pkg::DIV5_SHIFT];
            default:             n_chan = r_pix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule
